>>> hw/rtl/cor_pkg.sv
// package: item, result and register-file types, opcode and cycle constants
package cor_pkg;

  // one instruction as it arrives
  typedef struct packed {
    logic [4:0] opcode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] read_data;
  } item_t;

  // what one instruction reports
  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [3:0]  cycle_count;
    logic        stop_request;
    logic [15:0] next_pc;
    logic [3:0]  flags_now;
  } result_t;

  // architectural registers touched by this opcode row
  typedef struct packed {
    logic [7:0]  accumulator;
    logic [7:0]  reg_dhigh;
    logic [7:0]  reg_elow;
    logic [7:0]  reg_hhigh;
    logic [7:0]  reg_llow;
    logic [3:0]  flag_bits;
    logic [15:0] prog_counter;
  } arch_t;

  // low nibble of the opcode
  localparam logic [3:0] OP_STOP     = 4'h0;
  localparam logic [3:0] OP_LD_DE_NN = 4'h1;
  localparam logic [3:0] OP_ST_DE_A  = 4'h2;
  localparam logic [3:0] OP_INC_DE   = 4'h3;
  localparam logic [3:0] OP_INC_D    = 4'h4;
  localparam logic [3:0] OP_DEC_D    = 4'h5;
  localparam logic [3:0] OP_LD_D_N   = 4'h6;
  localparam logic [3:0] OP_RLA      = 4'h7;
  localparam logic [3:0] OP_JR       = 4'h8;
  localparam logic [3:0] OP_ADD_HL   = 4'h9;
  localparam logic [3:0] OP_LD_A_DE  = 4'ha;
  localparam logic [3:0] OP_DEC_DE   = 4'hb;
  localparam logic [3:0] OP_INC_E    = 4'hc;
  localparam logic [3:0] OP_DEC_E    = 4'hd;
  localparam logic [3:0] OP_LD_E_N   = 4'he;
  localparam logic [3:0] OP_RRA      = 4'hf;

  // cycle counts
  localparam logic [3:0] CYC_4  = 4'd4;
  localparam logic [3:0] CYC_8  = 4'd8;
  localparam logic [3:0] CYC_12 = 4'd12;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [3:0] NIBBLE_ONES = 4'hf;

endpackage

>>> hw/rtl/cor_exec.sv
// execute logic: next register values and result for one instruction
module cor_exec (
  input  cor_pkg::arch_t   cur,
  input  cor_pkg::item_t   item,
  output cor_pkg::arch_t   nxt,
  output cor_pkg::result_t res
);
  import cor_pkg::*;

  logic [3:0]  sel;
  logic [15:0] de;
  logic [15:0] hl;
  logic [16:0] hl_sum;
  logic [12:0] half_sum;
  logic [15:0] pc_base;
  logic [1:0]  len;
  logic [7:0]  inc_src;
  logic [7:0]  inc_res;
  logic [3:0]  inc_flags;
  logic [7:0]  dec_src;
  logic [7:0]  dec_res;
  logic [3:0]  dec_flags;
  logic        carry_in;

  assign sel      = item.opcode[3:0];
  assign de       = {cur.reg_dhigh, cur.reg_elow};
  assign hl       = {cur.reg_hhigh, cur.reg_llow};
  assign hl_sum   = {1'b0, hl} + {1'b0, de};
  assign half_sum = {1'b0, hl[11:0]} + {1'b0, de[11:0]};
  assign carry_in = cur.flag_bits[FLAG_C];

  // shared 8-bit increment / decrement for D or E (opcode bit 3 picks E)
  assign inc_src = sel[3] ? cur.reg_elow : cur.reg_dhigh;
  assign inc_res = inc_src + 8'd1;
  assign dec_src = inc_src;
  assign dec_res = dec_src - 8'd1;

  always_comb begin
    inc_flags         = '0;
    inc_flags[FLAG_Z] = (inc_res == 8'd0);
    inc_flags[FLAG_H] = (inc_src[3:0] == NIBBLE_ONES);
    inc_flags[FLAG_C] = carry_in;
    dec_flags         = '0;
    dec_flags[FLAG_Z] = (dec_res == 8'd0);
    dec_flags[FLAG_N] = 1'b1;
    dec_flags[FLAG_H] = (dec_src[3:0] == 4'h0);
    dec_flags[FLAG_C] = carry_in;
  end

  // instruction decode and register update
  always_comb begin
    nxt               = cur;
    pc_base           = cur.prog_counter;
    len               = 2'd1;
    res               = '0;
    res.cycle_count   = CYC_4;
    unique case (sel)
      OP_STOP: begin
        res.stop_request = 1'b1;
        len              = 2'd2;
      end
      OP_LD_DE_NN: begin
        nxt.reg_dhigh   = item.imm_high;
        nxt.reg_elow    = item.imm_low;
        len             = 2'd3;
        res.cycle_count = CYC_12;
      end
      OP_ST_DE_A: begin
        res.write_enable  = 1'b1;
        res.write_address = de;
        res.write_data    = cur.accumulator;
        res.cycle_count   = CYC_8;
      end
      OP_INC_DE: begin
        {nxt.reg_dhigh, nxt.reg_elow} = de + 16'd1;
        res.cycle_count               = CYC_8;
      end
      OP_DEC_DE: begin
        {nxt.reg_dhigh, nxt.reg_elow} = de - 16'd1;
        res.cycle_count               = CYC_8;
      end
      OP_INC_D: begin
        nxt.reg_dhigh = inc_res;
        nxt.flag_bits = inc_flags;
      end
      OP_DEC_D: begin
        nxt.reg_dhigh = dec_res;
        nxt.flag_bits = dec_flags;
      end
      OP_INC_E: begin
        nxt.reg_elow  = inc_res;
        nxt.flag_bits = inc_flags;
      end
      OP_DEC_E: begin
        nxt.reg_elow  = dec_res;
        nxt.flag_bits = dec_flags;
      end
      OP_LD_D_N: begin
        nxt.reg_dhigh   = item.imm_low;
        len             = 2'd2;
        res.cycle_count = CYC_8;
      end
      OP_LD_E_N: begin
        nxt.reg_elow    = item.imm_low;
        len             = 2'd2;
        res.cycle_count = CYC_8;
      end
      OP_RLA: begin
        nxt.accumulator         = {cur.accumulator[6:0], carry_in};
        nxt.flag_bits           = '0;
        nxt.flag_bits[FLAG_C]   = cur.accumulator[7];
      end
      OP_JR: begin
        // target is opcode address + 2 + signed offset
        pc_base         = cur.prog_counter + 16'd2 + {{8{item.imm_low[7]}}, item.imm_low};
        len             = 2'd0;
        res.cycle_count = CYC_12;
      end
      OP_ADD_HL: begin
        nxt.reg_hhigh         = hl_sum[15:8];
        nxt.reg_llow          = hl_sum[7:0];
        nxt.flag_bits         = '0;
        nxt.flag_bits[FLAG_Z] = cur.flag_bits[FLAG_Z];
        nxt.flag_bits[FLAG_H] = half_sum[12];
        nxt.flag_bits[FLAG_C] = hl_sum[16];
        res.cycle_count       = CYC_8;
      end
      OP_LD_A_DE: begin
        nxt.accumulator = item.read_data;
        res.cycle_count = CYC_8;
      end
      default: begin
        // rotate right through carry
        nxt.accumulator       = {carry_in, cur.accumulator[7:1]};
        nxt.flag_bits         = '0;
        nxt.flag_bits[FLAG_C] = cur.accumulator[0];
      end
    endcase
    nxt.prog_counter = pc_base + {14'd0, len};
    res.next_pc      = nxt.prog_counter;
    res.flags_now    = nxt.flag_bits;
  end

endmodule

>>> hw/rtl/cpu_opcode_row_execute.sv
// top level: instruction register, execute step and result register
//
//   channel   direction  signals                           payload
//   item      in         item_valid / item_ready           item (item_t)
//   result    out        result_valid / result_ready       result (result_t)
//
// An instruction lands in the input register at its transfer and executes
// against the register file once the result register can take it, updating
// it as the result register loads: one instruction per cycle sustained while
// result_ready is high. Reset (rst, synchronous) clears the register file and
// both valid flags. A stalled result holds the instruction in the input
// register; a new one is still taken while that register is free.
module cpu_opcode_row_execute (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  cor_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output cor_pkg::result_t result
);
  import cor_pkg::*;

  logic    held_valid;
  item_t   held;
  arch_t   arch;
  arch_t   arch_next;
  result_t exec_res;
  logic    exec_fire;

  assign exec_fire  = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || exec_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

  cor_exec u_exec (
    .cur  (arch),
    .item (held),
    .nxt  (arch_next),
    .res  (exec_res)
  );

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= '0;
    end else if (exec_fire) begin
      arch <= arch_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      result <= exec_res;
    end
  end

endmodule
